/* sv/mfq_pkg.sv */
// ----------------------------------------------------------------------------
// mfq_pkg
// Shared types, field widths, register codes and defaults of the three-level
// feedback queue scheduler.
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int MaxJobsDefault    = 16;
    localparam int BurstWidthDefault = 16;

    localparam int IdWidth      = 4;
    localparam int LevelWidth   = 2;
    localparam int QuantWidth   = 8;
    localparam int WordWidth    = 16;
    localparam int CfgAddrWidth = 3;
    localparam int CfgDataWidth = 32;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_ARRIVE = 1'b1;

    localparam logic [LevelWidth-1:0] LVL_TOP = 2'd0;
    localparam logic [LevelWidth-1:0] LVL_MID = 2'd1;
    localparam logic [LevelWidth-1:0] LVL_BOT = 2'd2;

    localparam logic [QuantWidth-1:0] TopQuantumReset    = 8'd8;
    localparam logic [QuantWidth-1:0] MiddleQuantumReset = 8'd16;
    localparam logic [QuantWidth-1:0] SliceMax           = 8'd255;

    typedef enum logic {
        CFG_TOP_QUANTUM    = 1'b0,
        CFG_MIDDLE_QUANTUM = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
    } t_dp_status;

endpackage

/* sv/mfq_cfg.sv */
// ----------------------------------------------------------------------------
// mfq_cfg
// Register port holding the top and middle quanta.
// ----------------------------------------------------------------------------
module mfq_cfg import mfq_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [CfgDataWidth-1:0] pwdata,
    output logic [CfgDataWidth-1:0] prdata,
    output logic                    pready,
    output logic [QuantWidth-1:0]   o_top_quantum,
    output logic [QuantWidth-1:0]   o_middle_quantum
);

    logic [QuantWidth-1:0] r_top_quantum;
    logic [QuantWidth-1:0] r_middle_quantum;
    t_cfg_reg              w_reg;
    logic                  w_write;

    assign pready  = 1'b1;
    assign w_reg   = t_cfg_reg'(paddr[2]);
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_quantum    <= TopQuantumReset;
            r_middle_quantum <= MiddleQuantumReset;
        end else if (w_write) begin
            case (w_reg)
                CFG_TOP_QUANTUM:    r_top_quantum    <= pwdata[QuantWidth-1:0];
                CFG_MIDDLE_QUANTUM: r_middle_quantum <= pwdata[QuantWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            CFG_TOP_QUANTUM:    prdata = CfgDataWidth'(r_top_quantum);
            CFG_MIDDLE_QUANTUM: prdata = CfgDataWidth'(r_middle_quantum);
            default:            prdata = '0;
        endcase
    end

    assign o_top_quantum    = r_top_quantum;
    assign o_middle_quantum = r_middle_quantum;

endmodule

/* sv/mfq_ctrl.sv */
// ----------------------------------------------------------------------------
// mfq_ctrl
// Sequencer: loads an input word, then runs it once the result slot is free.
// ----------------------------------------------------------------------------
module mfq_ctrl import mfq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                // a finishing word makes room for the next one in the same cycle
                if (i_status.slot_free && !i_in_valid) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_EXEC: begin
                o_in_stall = !i_status.slot_free;
                o_cmd.exec = i_status.slot_free;
                o_cmd.load = i_in_valid && i_status.slot_free;
            end
            default: ;
        endcase
    end

endmodule

/* sv/mfq_datapath.sv */
// ----------------------------------------------------------------------------
// mfq_datapath
// Queues, burst counters, current job and result register of the scheduler.
// ----------------------------------------------------------------------------
module mfq_datapath import mfq_pkg::*; #(
    parameter int MAX_JOBS    = MaxJobsDefault,
    parameter int BURST_WIDTH = BurstWidthDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_command,
    input  logic [IdWidth-1:0]    i_job_id,
    input  logic [WordWidth-1:0]  i_burst_length,
    input  logic                  i_out_stall,
    input  logic [QuantWidth-1:0] i_top_quantum,
    input  logic [QuantWidth-1:0] i_middle_quantum,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output logic                  o_accepted,
    output logic                  o_busy_res,
    output logic [IdWidth-1:0]    o_running_id,
    output logic [LevelWidth-1:0] o_running_level,
    output logic                  o_job_done,
    output logic [WordWidth-1:0]  o_remaining_work
);

    // ids are IdWidth bits, so no more than 2**IdWidth jobs can ever be live
    localparam int NJ = (MAX_JOBS < (1 << IdWidth)) ? MAX_JOBS : (1 << IdWidth);
    localparam int IW = (NJ > 1) ? $clog2(NJ) : 1;
    localparam int CW = IW + 1;
    localparam int NL = 3;

    // captured input word
    logic                   r_in_cmd;
    logic [IdWidth-1:0]     r_in_id;
    logic [BURST_WIDTH-1:0] r_in_burst;

    // queues
    logic [IdWidth-1:0]     r_fifo  [NL][NJ];
    logic [IW-1:0]          r_head  [NL];
    logic [CW-1:0]          r_count [NL];
    logic [IW-1:0]          n_head  [NL];
    logic [CW-1:0]          n_count [NL];
    logic [IW-1:0]          w_tail  [NL];
    logic [CW-1:0]          w_sum   [NL];
    logic                   w_push_ok [NL];
    logic                   w_push_en [NL];
    logic [IdWidth-1:0]     w_push_id [NL];
    logic                   w_pop_en  [NL];

    // job state
    logic [BURST_WIDTH-1:0] r_burst [NJ];
    logic [NJ-1:0]          r_active;
    logic [NJ-1:0]          n_active;
    logic                   r_cur_valid;
    logic                   n_cur_valid;
    logic [IdWidth-1:0]     r_cur_job;
    logic [IdWidth-1:0]     n_cur_job;
    logic [LevelWidth-1:0]  r_cur_level;
    logic [LevelWidth-1:0]  n_cur_level;
    logic [QuantWidth-1:0]  r_slice;
    logic [QuantWidth-1:0]  n_slice;

    logic                   w_burst_we;
    logic [IW-1:0]          w_burst_addr;
    logic [BURST_WIDTH-1:0] w_burst_wdata;

    // tick selection
    logic                   w_found;
    logic [IdWidth-1:0]     w_sel_job;
    logic [LevelWidth-1:0]  w_sel_level;
    logic [QuantWidth-1:0]  w_sel_slice;
    logic [QuantWidth-1:0]  w_slice_inc;
    logic [QuantWidth-1:0]  w_quant;
    logic [QuantWidth-1:0]  w_quant_eff;
    logic [BURST_WIDTH-1:0] w_left;
    logic                   w_done;
    logic                   w_id_ok;
    logic [IW-1:0]          w_in_idx;

    // result
    logic                   r_out_valid;
    logic                   n_accepted;
    logic                   n_busy;
    logic [IdWidth-1:0]     n_run_id;
    logic [LevelWidth-1:0]  n_run_level;
    logic                   n_done;
    logic [WordWidth-1:0]   n_remaining;
    logic                   r_accepted;
    logic                   r_busy;
    logic [IdWidth-1:0]     r_run_id;
    logic [LevelWidth-1:0]  r_run_level;
    logic                   r_done;
    logic [WordWidth-1:0]   r_remaining;

    assign o_status.slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_cmd   <= i_command;
            r_in_id    <= i_job_id;
            r_in_burst <= BURST_WIDTH'(i_burst_length);
        end
    end

    assign w_id_ok  = int'(r_in_id) < NJ;
    assign w_in_idx = r_in_id[IW-1:0];

    // tail = head + count, wrapped once
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            w_sum[l]     = CW'(r_head[l]) + r_count[l];
            w_tail[l]    = (w_sum[l] >= CW'(NJ)) ? IW'(w_sum[l] - CW'(NJ)) : IW'(w_sum[l]);
            w_push_ok[l] = w_push_en[l] && (r_count[l] < CW'(NJ));
            if (w_pop_en[l]) begin
                n_head[l] = (r_head[l] == IW'(NJ - 1)) ? '0 : IW'(r_head[l] + 1'b1);
            end else begin
                n_head[l] = r_head[l];
            end
            n_count[l] = CW'(r_count[l] + CW'(w_push_ok[l]) - CW'(w_pop_en[l]));
        end
    end

    always_comb begin
        n_active      = r_active;
        n_cur_valid   = r_cur_valid;
        n_cur_job     = r_cur_job;
        n_cur_level   = r_cur_level;
        n_slice       = r_slice;
        w_burst_we    = 1'b0;
        w_burst_addr  = w_in_idx;
        w_burst_wdata = r_in_burst;
        for (int l = 0; l < NL; l++) begin
            w_push_en[l] = 1'b0;
            w_push_id[l] = '0;
            w_pop_en[l]  = 1'b0;
        end
        w_found     = r_cur_valid;
        w_sel_job   = r_cur_job;
        w_sel_level = r_cur_level;
        w_sel_slice = r_slice;
        w_left      = '0;
        w_done      = 1'b0;
        w_slice_inc = '0;
        w_quant     = '0;
        w_quant_eff = '0;
        n_accepted  = 1'b1;
        n_busy      = 1'b0;
        n_run_id    = '0;
        n_run_level = '0;
        n_done      = 1'b0;
        n_remaining = '0;

        if (i_cmd.exec) begin
            if (r_in_cmd == CMD_ARRIVE) begin
                if (!w_id_ok || r_active[w_in_idx]) begin
                    n_accepted = 1'b0;
                end else if (r_in_burst != '0) begin
                    w_burst_we          = 1'b1;
                    n_active[w_in_idx]  = 1'b1;
                    w_push_en[0]        = 1'b1;
                    w_push_id[0]        = r_in_id;
                    // preempt a middle or bottom job back to its own queue
                    if (r_cur_valid && r_cur_level != LVL_TOP) begin
                        w_push_en[r_cur_level] = 1'b1;
                        w_push_id[r_cur_level] = r_cur_job;
                        n_cur_valid            = 1'b0;
                        n_slice                = '0;
                    end
                end
            end else begin
                if (!r_cur_valid) begin
                    w_sel_slice = '0;
                    if (r_count[0] != '0) begin
                        w_found     = 1'b1;
                        w_pop_en[0] = 1'b1;
                        w_sel_job   = r_fifo[0][r_head[0]];
                        w_sel_level = LVL_TOP;
                    end else if (r_count[1] != '0) begin
                        w_found     = 1'b1;
                        w_pop_en[1] = 1'b1;
                        w_sel_job   = r_fifo[1][r_head[1]];
                        w_sel_level = LVL_MID;
                    end else if (r_count[2] != '0) begin
                        w_found     = 1'b1;
                        w_pop_en[2] = 1'b1;
                        w_sel_job   = r_fifo[2][r_head[2]];
                        w_sel_level = LVL_BOT;
                    end
                end
                if (w_found) begin
                    w_left = r_burst[w_sel_job[IW-1:0]];
                    if (w_left != '0) w_left = w_left - 1'b1;
                    w_done        = (w_left == '0);
                    w_burst_we    = 1'b1;
                    w_burst_addr  = w_sel_job[IW-1:0];
                    w_burst_wdata = w_left;
                    w_slice_inc   = (w_sel_slice == SliceMax) ? w_sel_slice
                                                              : QuantWidth'(w_sel_slice + 1'b1);
                    w_quant       = (w_sel_level == LVL_TOP) ? i_top_quantum : i_middle_quantum;
                    w_quant_eff   = (w_quant == '0) ? QuantWidth'(1) : w_quant;

                    n_busy      = 1'b1;
                    n_run_id    = w_sel_job;
                    n_run_level = w_sel_level;
                    n_done      = w_done;
                    n_remaining = WordWidth'(w_left);

                    if (w_done) begin
                        n_active[w_sel_job[IW-1:0]] = 1'b0;
                        n_cur_valid = 1'b0;
                        n_slice     = '0;
                    end else if (w_sel_level != LVL_BOT && w_slice_inc >= w_quant_eff) begin
                        // quantum used up: drop one level
                        w_push_en[LevelWidth'(w_sel_level + 1'b1)] = 1'b1;
                        w_push_id[LevelWidth'(w_sel_level + 1'b1)] = w_sel_job;
                        n_cur_valid = 1'b0;
                        n_slice     = '0;
                    end else begin
                        n_cur_valid = 1'b1;
                        n_cur_job   = w_sel_job;
                        n_cur_level = w_sel_level;
                        n_slice     = w_slice_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            if (w_push_ok[l]) r_fifo[l][w_tail[l]] <= w_push_id[l];
        end
        if (w_burst_we) r_burst[w_burst_addr] <= w_burst_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NL; l++) begin
                r_head[l]  <= '0;
                r_count[l] <= '0;
            end
            r_active    <= '0;
            r_cur_valid <= 1'b0;
            r_cur_job   <= '0;
            r_cur_level <= '0;
            r_slice     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            for (int l = 0; l < NL; l++) begin
                r_head[l]  <= n_head[l];
                r_count[l] <= n_count[l];
            end
            r_active    <= n_active;
            r_cur_valid <= n_cur_valid;
            r_cur_job   <= n_cur_job;
            r_cur_level <= n_cur_level;
            r_slice     <= n_slice;
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_accepted  <= n_accepted;
            r_busy      <= n_busy;
            r_run_id    <= n_run_id;
            r_run_level <= n_run_level;
            r_done      <= n_done;
            r_remaining <= n_remaining;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_busy_res       = r_busy;
    assign o_running_id     = r_run_id;
    assign o_running_level  = r_run_level;
    assign o_job_done       = r_done;
    assign o_remaining_work = r_remaining;

endmodule

/* sv/multilevel_feedback_queue_scheduler_core.sv */
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_core
// Three-level feedback queue scheduler driven by tick and arrival words.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one word per tick or job arrival.
// Output channel (o_out_valid / i_out_stall): exactly one result word per
// input word, in order.
// Register port: top quantum at byte 0, middle quantum at byte 4; write only
// while the block is idle.
// Throughput: one word per cycle while the result is not stalled; the whole
// step (queue pop or push, burst decrement, quantum compare) is done
// combinationally by the datapath from a captured input word, and a result
// register parts the two channels.
// Reset: all queues empty, no job active, quanta back to 8 and 16; no
// clearing pass is needed.
// Stall: a stalled result holds in its register; the word being worked on
// waits behind it and the input channel stalls until the result is taken.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_core import mfq_pkg::*; #(
    parameter int MAX_JOBS    = MaxJobsDefault,
    parameter int BURST_WIDTH = BurstWidthDefault
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_command,
    input  logic [IdWidth-1:0]      i_job_id,
    input  logic [WordWidth-1:0]    i_burst_length,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_accepted,
    output logic                    o_busy_res,
    output logic [IdWidth-1:0]      o_running_id,
    output logic [LevelWidth-1:0]   o_running_level,
    output logic                    o_job_done,
    output logic [WordWidth-1:0]    o_remaining_work,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CfgAddrWidth-1:0] paddr,
    input  logic [CfgDataWidth-1:0] pwdata,
    output logic [CfgDataWidth-1:0] prdata,
    output logic                    pready
);

    t_dp_cmd               w_cmd;
    t_dp_status            w_status;
    logic [QuantWidth-1:0] w_top_quantum;
    logic [QuantWidth-1:0] w_middle_quantum;

    mfq_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_top_quantum    (w_top_quantum),
        .o_middle_quantum (w_middle_quantum)
    );

    mfq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    mfq_datapath #(
        .MAX_JOBS    (MAX_JOBS),
        .BURST_WIDTH (BURST_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_command        (i_command),
        .i_job_id         (i_job_id),
        .i_burst_length   (i_burst_length),
        .i_out_stall      (i_out_stall),
        .i_top_quantum    (w_top_quantum),
        .i_middle_quantum (w_middle_quantum),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_accepted       (o_accepted),
        .o_busy_res       (o_busy_res),
        .o_running_id     (o_running_id),
        .o_running_level  (o_running_level),
        .o_job_done       (o_job_done),
        .o_remaining_work (o_remaining_work)
    );

endmodule

/* sv/mfq_checker.sv */
// ----------------------------------------------------------------------------
// mfq_checker
// Port-level checks on the scheduler's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module mfq_checker import mfq_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_accepted,
    input logic                  o_busy_res,
    input logic [IdWidth-1:0]    o_running_id,
    input logic [LevelWidth-1:0] o_running_level,
    input logic                  o_job_done,
    input logic [WordWidth-1:0]  o_remaining_work
);

    // no result word survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // hold a stalled result word
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_running_id)
            && $stable(o_remaining_work) && $stable(o_busy_res) && $stable(o_accepted))
        else $error("stalled result changed");

    // only ticks run a job, and ticks are always accepted
    a_busy_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_busy_res |-> o_accepted && o_running_level != 2'd3)
        else $error("busy result on an arrival");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_busy_res && o_job_done |-> o_remaining_work == '0)
        else $error("finished job with work left");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_busy_res |-> o_running_id == '0 && o_running_level == '0
            && !o_job_done && o_remaining_work == '0)
        else $error("idle result carries job fields");

endmodule

bind multilevel_feedback_queue_scheduler_core mfq_checker u_mfq_checker (.*);
